// File: hdl/fszm_pkg.sv
// Shared types and constants for the fuzzy S/Z membership block.
// No dependencies; compiled first.
package fszm_pkg;

   // Default sizes
   localparam int SAMPLE_WIDTH_DEF  = 16;
   localparam int FRACTION_BITS_DEF = 15;
   // Extra quotient bits kept below the output fraction
   localparam int GUARD_BITS        = 4;
   // Result field width is fixed
   localparam int DEGREE_WIDTH      = 16;

   // Control register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOWER_EDGE   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CENTER_POINT = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UPPER_EDGE   = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHAPE_SELECT = 2'd3;

   // Reset values of the control registers
   localparam int LOWER_EDGE_RST   = 0;
   localparam int CENTER_POINT_RST = 128;
   localparam int UPPER_EDGE_RST   = 256;
   localparam logic SHAPE_SELECT_RST = 1'b1;

   // Which piece of the S curve a sample falls on
   localparam logic [1:0] MODE_ZERO = 2'd0;
   localparam logic [1:0] MODE_ONE  = 2'd1;
   localparam logic [1:0] MODE_RISE = 2'd2;
   localparam logic [1:0] MODE_FALL = 2'd3;

   // Per-request control that rides along the pipeline
   typedef struct packed {
      logic [1:0] mode;
      logic       shape;  // 1: S curve, 0: Z curve
      logic       sat;    // distance at or beyond the width
   } fszm_side_type;

endpackage

// File: hdl/fszm_if.sv
// Request and response channel interfaces (valid/ready handshake).
// Depends on fszm_pkg.
interface fszm_req_if #(
   parameter int SAMPLE_WIDTH = fszm_pkg::SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface fszm_rsp_if;
   import fszm_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [DEGREE_WIDTH-1:0] degree;

   modport source (output valid, output degree, input ready);
   modport sink   (input valid, input degree, output ready);
endinterface

// File: hdl/fszm_div_step.sv
// One registered stage of the restoring divider: produces one quotient bit.
// Depends on fszm_pkg for the sideband type.
module fszm_div_step #(
   parameter int DIV_WIDTH  = fszm_pkg::SAMPLE_WIDTH_DEF,
   parameter int QUOT_WIDTH = fszm_pkg::FRACTION_BITS_DEF + fszm_pkg::GUARD_BITS
) (
   input  logic                    clock,
   input  logic                    load,
   input  logic [DIV_WIDTH-1:0]    rem_in,
   input  logic [QUOT_WIDTH-1:0]   quot_in,
   input  logic [DIV_WIDTH-1:0]    div_in,
   input  fszm_pkg::fszm_side_type side_in,
   output logic [DIV_WIDTH-1:0]    rem_out,
   output logic [QUOT_WIDTH-1:0]   quot_out,
   output logic [DIV_WIDTH-1:0]    div_out,
   output fszm_pkg::fszm_side_type side_out
);
   import fszm_pkg::*;

   logic [DIV_WIDTH:0]     rem_shift;
   logic                   take;
   logic [DIV_WIDTH:0]     rem_diff;
   logic [DIV_WIDTH-1:0]   rem_in_next;
   logic [QUOT_WIDTH-1:0]  quot_in_next;

   logic [DIV_WIDTH-1:0]   rem_ff;
   logic [QUOT_WIDTH-1:0]  quot_ff;
   logic [DIV_WIDTH-1:0]   div_ff;
   fszm_side_type          side_ff;

   // Shift in a zero, subtract the divisor where it fits
   always_comb begin
      rem_shift    = {rem_in, 1'b0};
      take         = (rem_shift >= {1'b0, div_in});
      rem_diff     = rem_shift - {1'b0, div_in};
      rem_in_next  = take ? rem_diff[DIV_WIDTH-1:0] : rem_shift[DIV_WIDTH-1:0];
      quot_in_next = {quot_in[QUOT_WIDTH-2:0], take};
   end

   // Payload only; valid bits live in the top level
   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff  <= rem_in_next;
         quot_ff <= quot_in_next;
         div_ff  <= div_in;
         side_ff <= side_in;
      end
   end

   assign rem_out  = rem_ff;
   assign quot_out = quot_ff;
   assign div_out  = div_ff;
   assign side_out = side_ff;

endmodule

// File: hdl/fuzzy_s_z_membership.sv
// Fuzzy S/Z membership: quadratic S curve or mirrored Z curve, Q1.15 result.
// Depends on fszm_pkg, fszm_if (channel interfaces) and fszm_div_step.
//
//   channel   dir   handshake        payload
//   req_chan  in    valid / ready    sample (signed, SAMPLE_WIDTH)
//   rsp_chan  out   valid / ready    degree (unsigned Q1.15, 16 bits)
//   csr_*     in    write enable     index (2 bits), data (SAMPLE_WIDTH)
//
// The pipeline has one decode stage, one restoring divider stage per quotient
// bit, a square stage and an output stage. One request is taken every cycle
// unless every stage is full and the output is stalled.
// Reset (synchronous) clears all valid bits and loads the register defaults.
// A stalled output holds its result; stages behind it keep filling until full.
module fuzzy_s_z_membership #(
   parameter int SAMPLE_WIDTH  = fszm_pkg::SAMPLE_WIDTH_DEF,
   parameter int FRACTION_BITS = fszm_pkg::FRACTION_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   fszm_req_if.sink                             req_chan,
   fszm_rsp_if.source                           rsp_chan,
   input  logic                                 csr_write_enable,
   input  logic [fszm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [SAMPLE_WIDTH-1:0]              csr_write_data
);
   import fszm_pkg::*;

   localparam int QW     = FRACTION_BITS + GUARD_BITS;  // quotient bits
   localparam int PW     = 2 * QW;                      // square width
   localparam int SHIFT  = FRACTION_BITS + 2 * GUARD_BITS - 1;
   localparam int TW     = PW + 1 - SHIFT;              // term width, F+2
   localparam int SW     = FRACTION_BITS + 1;           // degree before mask
   localparam int EXT_W  = (SW > DEGREE_WIDTH) ? SW : DEGREE_WIDTH;
   localparam int STAGES = QW + 3;
   localparam int SQ_ST  = QW + 1;
   localparam int OUT_ST = QW + 2;

   localparam logic [PW:0]   ROUND_C = (PW + 1)'(1) << (SHIFT - 1);
   localparam logic [TW-1:0] ONE_T   = TW'(1) << FRACTION_BITS;
   localparam logic [SW-1:0] ONE_S   = SW'(1) << FRACTION_BITS;

   // ---------------- control registers ----------------
   logic signed [SAMPLE_WIDTH-1:0] lower_edge_ff;
   logic signed [SAMPLE_WIDTH-1:0] center_point_ff;
   logic signed [SAMPLE_WIDTH-1:0] upper_edge_ff;
   logic                           shape_select_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_edge_ff   <= SAMPLE_WIDTH'(LOWER_EDGE_RST);
         center_point_ff <= SAMPLE_WIDTH'(CENTER_POINT_RST);
         upper_edge_ff   <= SAMPLE_WIDTH'(UPPER_EDGE_RST);
         shape_select_ff <= SHAPE_SELECT_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LOWER_EDGE:   lower_edge_ff   <= csr_write_data;
            CSR_CENTER_POINT: center_point_ff <= csr_write_data;
            CSR_UPPER_EDGE:   upper_edge_ff   <= csr_write_data;
            CSR_SHAPE_SELECT: shape_select_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // ---------------- flow control ----------------
   // A stage moves when any stage at or after it is empty, or the output drains.
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] adv;

   for (genvar k = 0; k < STAGES; k++) begin : g_adv
      assign adv[k] = rsp_chan.ready || !(&valid_ff[STAGES-1:k]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_chan.valid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign req_chan.ready = adv[0];

   // ---------------- stage 0: piece decode ----------------
   logic signed [SAMPLE_WIDTH:0] x_ext, lo_ext, mid_ext, hi_ext;
   logic [SAMPLE_WIDTH:0]        x_minus_lo, hi_minus_x, hi_minus_lo;
   logic [SAMPLE_WIDTH-1:0]      dist_in;
   fszm_side_type                side_a_in;

   logic [SAMPLE_WIDTH-1:0]      dist_a_ff;
   logic [SAMPLE_WIDTH-1:0]      width_a_ff;
   fszm_side_type                side_a_ff;

   always_comb begin
      x_ext   = {req_chan.sample[SAMPLE_WIDTH-1], req_chan.sample};
      lo_ext  = {lower_edge_ff[SAMPLE_WIDTH-1], lower_edge_ff};
      mid_ext = {center_point_ff[SAMPLE_WIDTH-1], center_point_ff};
      hi_ext  = {upper_edge_ff[SAMPLE_WIDTH-1], upper_edge_ff};
      x_minus_lo  = x_ext - lo_ext;
      hi_minus_x  = hi_ext - x_ext;
      hi_minus_lo = hi_ext - lo_ext;

      side_a_in.shape = shape_select_ff;
      side_a_in.sat   = 1'b0;
      dist_in         = x_minus_lo[SAMPLE_WIDTH-1:0];
      if (x_ext <= lo_ext) begin
         side_a_in.mode = MODE_ZERO;
      end else if (hi_ext <= lo_ext) begin
         // empty or reversed span: plain step
         side_a_in.mode = MODE_ONE;
      end else if (x_ext <= mid_ext) begin
         side_a_in.mode = MODE_RISE;
      end else if (x_ext < hi_ext) begin
         side_a_in.mode = MODE_FALL;
         dist_in        = hi_minus_x[SAMPLE_WIDTH-1:0];
      end else begin
         side_a_in.mode = MODE_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         dist_a_ff  <= dist_in;
         width_a_ff <= hi_minus_lo[SAMPLE_WIDTH-1:0];
         side_a_ff  <= side_a_in;
      end
   end

   // ---------------- divider: ratio = dist * 2^QW / width ----------------
   logic [SAMPLE_WIDTH-1:0] rem_s  [0:QW];
   logic [QW-1:0]           quot_s [0:QW];
   logic [SAMPLE_WIDTH-1:0] div_s  [0:QW];
   fszm_side_type           side_s [0:QW];

   // distance at or past the width saturates; flagged beside the first step
   always_comb begin
      rem_s[0]      = dist_a_ff;
      quot_s[0]     = '0;
      div_s[0]      = width_a_ff;
      side_s[0]     = side_a_ff;
      side_s[0].sat = (dist_a_ff >= width_a_ff);
   end

   for (genvar k = 0; k < QW; k++) begin : g_div
      fszm_div_step #(
         .DIV_WIDTH  (SAMPLE_WIDTH),
         .QUOT_WIDTH (QW)
      ) u_step (
         .clock    (clock),
         .load     (adv[k+1]),
         .rem_in   (rem_s[k]),
         .quot_in  (quot_s[k]),
         .div_in   (div_s[k]),
         .side_in  (side_s[k]),
         .rem_out  (rem_s[k+1]),
         .quot_out (quot_s[k+1]),
         .div_out  (div_s[k+1]),
         .side_out (side_s[k+1])
      );
   end

   // ---------------- square stage ----------------
   logic [PW-1:0]  square_ff;
   fszm_side_type  side_p_ff;

   always_ff @(posedge clock) begin
      if (adv[SQ_ST]) begin
         square_ff <= quot_s[QW] * quot_s[QW];
         side_p_ff <= side_s[QW];
      end
   end

   // ---------------- output stage: round, clamp, mirror ----------------
   logic [PW:0]     round_sum;
   logic [TW-1:0]   term;
   logic [SW-1:0]   s_val;
   logic [SW-1:0]   deg_q;
   logic [EXT_W-1:0] deg_ext;
   logic [DEGREE_WIDTH-1:0] degree_ff;

   always_comb begin
      round_sum = {1'b0, square_ff} + ROUND_C;
      term      = round_sum[PW:SHIFT];
      case (side_p_ff.mode)
         MODE_ZERO: s_val = '0;
         MODE_ONE:  s_val = ONE_S;
         MODE_RISE: s_val = (side_p_ff.sat || term > ONE_T) ? ONE_S : term[SW-1:0];
         MODE_FALL: s_val = (side_p_ff.sat || term >= ONE_T) ? '0 :
                            ONE_S - term[SW-1:0];
         default:   s_val = '0;
      endcase
      deg_q   = side_p_ff.shape ? s_val : ONE_S - s_val;
      deg_ext = EXT_W'(deg_q);
   end

   always_ff @(posedge clock) begin
      if (adv[OUT_ST]) begin
         degree_ff <= deg_ext[DEGREE_WIDTH-1:0];
      end
   end

   assign rsp_chan.valid  = valid_ff[OUT_ST];
   assign rsp_chan.degree = degree_ff;

   // ---------------- assertions ----------------
   // an accepted request shows up in the decode stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> valid_ff[0])
      else $error("accepted request missing from decode stage");

   // back-pressure only when every stage is full and the output is blocked
   a_ready_low_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> ((&valid_ff) && !rsp_chan.ready))
      else $error("request refused with room in the pipeline");

   // a held divider stage keeps its quotient
   a_div_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[QW] && !adv[QW]) |=> (valid_ff[QW] && $stable(quot_s[QW])))
      else $error("stalled divider stage changed");

   // degree never exceeds one before masking
   a_degree_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[SQ_ST] |-> (deg_q <= ONE_S))
      else $error("degree above one");

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the fuzzy S/Z membership block: directed table, then random phases.
// Depends on fszm_pkg, fszm_if and fuzzy_s_z_membership from the hdl folder.
`timescale 1ns / 1ps

module tb_top;
   import fszm_pkg::*;

   localparam int F_BITS       = FRACTION_BITS_DEF;
   localparam int PIPE_LATENCY = FRACTION_BITS_DEF + GUARD_BITS + 3;
   localparam longint unsigned DEGREE_ONE = 64'd1 << F_BITS;
   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_ITEMS  = 104;
   localparam int HOLD_CYCLES  = 300;
   localparam int DIRECTED_ROWS = 38;

   typedef enum {PACE_FULL, PACE_SENDER_GAPS, PACE_RECEIVER_STALLS, PACE_BOTH} pacing_type;

   // One row of the directed table: a register write or a sample request
   typedef struct packed {
      logic                       is_write;
      logic [CSR_INDEX_WIDTH-1:0] index;     // unused on sample rows
      logic [15:0]                value;
      logic signed [15:0]         sample;
      logic                       given;     // degree below is typed in
      logic [15:0]                degree;
   } directed_row_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [15:0] csr_write_data;

   fszm_req_if #(.SAMPLE_WIDTH(16)) req_chan ();
   fszm_rsp_if                      rsp_chan ();

   fuzzy_s_z_membership i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow of the curve registers
   logic signed [15:0] cfg_lower;
   logic signed [15:0] cfg_center;
   logic signed [15:0] cfg_upper;
   logic               cfg_shape;

   logic [15:0] pending_degrees[$];
   pacing_type  pacing = PACE_FULL;
   bit          pressure_armed = 1'b0;
   bit          pressure_hold = 1'b0;
   int          fail_count = 0;
   int          degrees_checked = 0;
   int          samples_sent = 0;
   int          settings_used = 1;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // reset curve: S, 0 / 128 / 256
      '{1'b0, CSR_LOWER_EDGE, 16'h0000, 16'sh8000, 1'b1, 16'd0},
      '{1'b0, CSR_LOWER_EDGE, 16'h0000, 16'sd0,    1'b1, 16'd0},
      '{1'b0, CSR_LOWER_EDGE, 16'h0000, 16'sd128,  1'b1, 16'd16384},
      '{1'b0, CSR_LOWER_EDGE, 16'h0000, 16'sd256,  1'b1, 16'd32768},
      '{1'b0, CSR_LOWER_EDGE, 16'h0000, 16'sh7fff, 1'b1, 16'd32768},
      '{1'b0, CSR_LOWER_EDGE, 16'h0000, 16'sd1,    1'b0, 16'd0},
      '{1'b0, CSR_LOWER_EDGE, 16'h0000, 16'sd255,  1'b0, 16'd0},
      // falling Z curve
      '{1'b1, CSR_SHAPE_SELECT, 16'h0000, 16'sd0, 1'b0, 16'd0},
      '{1'b0, CSR_LOWER_EDGE, 16'h0000, 16'sd0,    1'b1, 16'd32768},
      '{1'b0, CSR_LOWER_EDGE, 16'h0000, 16'sd128,  1'b1, 16'd16384},
      '{1'b0, CSR_LOWER_EDGE, 16'h0000, 16'sd300,  1'b1, 16'd0},
      '{1'b0, CSR_LOWER_EDGE, 16'h0000, 16'sd64,   1'b0, 16'd0},
      // empty span: step at the lower edge
      '{1'b1, CSR_LOWER_EDGE,   16'd100,  16'sd0, 1'b0, 16'd0},
      '{1'b1, CSR_UPPER_EDGE,   16'd100,  16'sd0, 1'b0, 16'd0},
      '{1'b1, CSR_SHAPE_SELECT, 16'hfffe | 16'h0001, 16'sd0, 1'b0, 16'd0},
      '{1'b0, CSR_LOWER_EDGE, 16'h0000, 16'sd100,  1'b1, 16'd0},
      '{1'b0, CSR_LOWER_EDGE, 16'h0000, 16'sd101,  1'b1, 16'd32768},
      // fully reversed span at the extremes
      '{1'b1, CSR_LOWER_EDGE,   16'h7fff, 16'sd0, 1'b0, 16'd0},
      '{1'b1, CSR_CENTER_POINT, 16'h0000, 16'sd0, 1'b0, 16'd0},
      '{1'b1, CSR_UPPER_EDGE,   16'h8000, 16'sd0, 1'b0, 16'd0},
      '{1'b0, CSR_LOWER_EDGE, 16'h0000, 16'sh7fff, 1'b1, 16'd0},
      '{1'b0, CSR_LOWER_EDGE, 16'h0000, 16'sh8000, 1'b1, 16'd0},
      // widest span, center at the top
      '{1'b1, CSR_LOWER_EDGE,   16'h8000, 16'sd0, 1'b0, 16'd0},
      '{1'b1, CSR_CENTER_POINT, 16'h7fff, 16'sd0, 1'b0, 16'd0},
      '{1'b1, CSR_UPPER_EDGE,   16'h7fff, 16'sd0, 1'b0, 16'd0},
      '{1'b0, CSR_LOWER_EDGE, 16'h0000, 16'sh7ffe, 1'b0, 16'd0},
      '{1'b0, CSR_LOWER_EDGE, 16'h0000, 16'sd0,    1'b0, 16'd0},
      '{1'b0, CSR_LOWER_EDGE, 16'h0000, 16'sh7fff, 1'b1, 16'd32768},
      // center on the lower edge
      '{1'b1, CSR_CENTER_POINT, 16'h8000, 16'sd0, 1'b0, 16'd0},
      '{1'b0, CSR_LOWER_EDGE, 16'h0000, 16'sh8001, 1'b0, 16'd0},
      '{1'b0, CSR_LOWER_EDGE, 16'h0000, 16'sd0,    1'b0, 16'd0},
      '{1'b0, CSR_LOWER_EDGE, 16'h0000, 16'sh8000, 1'b1, 16'd0},
      // center above the upper edge: distance reaches the width
      '{1'b1, CSR_LOWER_EDGE,   16'd0,   16'sd0, 1'b0, 16'd0},
      '{1'b1, CSR_CENTER_POINT, 16'd200, 16'sd0, 1'b0, 16'd0},
      '{1'b1, CSR_UPPER_EDGE,   16'd100, 16'sd0, 1'b0, 16'd0},
      '{1'b0, CSR_LOWER_EDGE, 16'h0000, 16'sd150,  1'b1, 16'd32768},
      '{1'b0, CSR_LOWER_EDGE, 16'h0000, 16'sd100,  1'b1, 16'd32768},
      '{1'b0, CSR_LOWER_EDGE, 16'h0000, 16'sd50,   1'b0, 16'd0}
   };

   // 2*(distance/span)^2 in Q1.15, rounded half up; 2.0 once distance reaches span
   function automatic longint unsigned curve_term(longint unsigned distance,
                                                  longint unsigned span);
      longint unsigned ratio;
      longint unsigned square;
      if (distance >= span)
         return 2 * DEGREE_ONE;
      ratio  = (distance << (F_BITS + GUARD_BITS)) / span;
      square = ratio * ratio;
      return (square + (64'd1 << (F_BITS + 2 * GUARD_BITS - 2)))
             >> (F_BITS + 2 * GUARD_BITS - 1);
   endfunction

   // Membership degree under the current register shadow
   function automatic logic [15:0] predict_degree(logic signed [15:0] x);
      longint xs, lo, mid, hi;
      longint unsigned term, level;
      xs  = x;
      lo  = cfg_lower;
      mid = cfg_center;
      hi  = cfg_upper;
      if (xs <= lo)
         level = 0;
      else if (hi <= lo)
         level = DEGREE_ONE;
      else if (xs <= mid) begin
         term  = curve_term(xs - lo, hi - lo);
         level = (term > DEGREE_ONE) ? DEGREE_ONE : term;
      end else if (xs < hi) begin
         term  = curve_term(hi - xs, hi - lo);
         level = (term >= DEGREE_ONE) ? 0 : DEGREE_ONE - term;
      end else
         level = DEGREE_ONE;
      if (!cfg_shape)
         level = DEGREE_ONE - level;
      return level[15:0];
   endfunction

   function automatic bit sender_idles();
      case (pacing)
         PACE_SENDER_GAPS: return $urandom_range(99) < 81;
         PACE_BOTH:        return $urandom_range(99) < 38;
         default:          return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (pacing)
         PACE_RECEIVER_STALLS: return $urandom_range(99) < 81;
         PACE_BOTH:            return $urandom_range(99) < 38;
         default:              return 1'b0;
      endcase
   endfunction

   // Mostly near the curve's span, some anywhere, some on the break points
   function automatic logic signed [15:0] pick_sample();
      int lo, hi, a, b, margin;
      lo = cfg_lower;
      hi = cfg_upper;
      a  = (lo < hi) ? lo : hi;
      b  = (lo < hi) ? hi : lo;
      margin = (b - a) / 8 + 2;
      a = (a - margin < -32768) ? -32768 : a - margin;
      b = (b + margin > 32767) ? 32767 : b + margin;
      if ($urandom_range(99) < 70)
         return 16'(a + int'($urandom_range(b - a)));
      if ($urandom_range(99) < 50)
         return 16'($urandom);
      case ($urandom_range(6))
         0: return cfg_lower;
         1: return cfg_center;
         2: return cfg_upper;
         3: return cfg_lower + 16'sd1;
         4: return cfg_upper - 16'sd1;
         5: return 16'sh8000;
         default: return 16'sh7fff;
      endcase
   endfunction

   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [15:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         CSR_LOWER_EDGE:   cfg_lower  = data;
         CSR_CENTER_POINT: cfg_center = data;
         CSR_UPPER_EDGE:   cfg_upper  = data;
         CSR_SHAPE_SELECT: cfg_shape  = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Offer one request; log its expected degree once accepted
   task automatic send_sample(logic signed [15:0] value, bit given, logic [15:0] degree);
      @(negedge clock);
      while (sender_idles()) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.sample <= value;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      pending_degrees.push_back(given ? degree : predict_degree(value));
      samples_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_degrees.size() != 0)
         @(posedge clock);
   endtask

   // Register setting for each random phase, extremes included
   task automatic configure_phase(int phase);
      int w, lo, mid, hi;
      bit shape;
      shape = $urandom_range(1);
      w  = 1;
      lo = -32768 + int'($urandom_range(65535));
      case (phase)
         1:       w = $urandom_range(512, 1);
         3:       w = $urandom_range(4096, 2);
         4:       w = $urandom_range(65535, 1);
         6:       w = $urandom_range(64, 1);
         default: ;
      endcase
      if (phase inside {1, 3, 4, 6})
         lo = -32768 + int'($urandom_range(65535 - w));
      hi  = lo + w;
      mid = lo + int'($urandom_range(w));
      case (phase)
         0: begin
            lo = -32768;
            hi = 32767;
            mid = -32768 + int'($urandom_range(65535));
            shape = 1'b1;
         end
         2: begin
            hi  = -32768 + int'($urandom_range(65535));
            mid = -32768 + int'($urandom_range(65535));
         end
         3: begin
            if ($urandom_range(1))
               mid = -32768 + int'($urandom_range(lo + 32768));
            else
               mid = hi + int'($urandom_range(32767 - hi));
         end
         5: begin
            hi  = lo - int'($urandom_range(lo + 32768));
            mid = -32768 + int'($urandom_range(65535));
         end
         6: shape = 1'b0;
         7: begin
            lo = -32768;
            hi = 32767;
            mid = $urandom_range(1) ? -32768 : 32767;
            shape = 1'b0;
         end
         default: ;
      endcase
      write_reg(CSR_LOWER_EDGE, 16'(lo));
      write_reg(CSR_CENTER_POINT, 16'(mid));
      write_reg(CSR_UPPER_EDGE, 16'(hi));
      write_reg(CSR_SHAPE_SELECT, {15'($urandom), shape});
      settings_used++;
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Response ready: random stalls per pacing, plus the long hold-off
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= !pressure_hold && !receiver_stalls();
      end
   end

   // Long receiver hold-off so the pipeline fills and back-pressures requests
   initial begin
      wait (pressure_armed);
      @(posedge clock);
      pressure_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      pressure_hold = 1'b0;
   end

   // Compare each response with the oldest expected degree
   always @(posedge clock) begin : check_degree
      logic [15:0] want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_degrees.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("ERROR: degree %0d arrived with no request outstanding",
                        rsp_chan.degree);
         end else begin
            want = pending_degrees.pop_front();
            degrees_checked++;
            if (rsp_chan.degree !== want) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("ERROR: degree mismatch at %0t: expected %0d, got %0d",
                           $realtime, want, rsp_chan.degree);
            end
         end
      end
   end

   // Stimulus: reset, directed table, random phases, drain
   initial begin : stimulus
      directed_row_type row;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.sample  = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_LOWER_EDGE;
      csr_write_data   = '0;
      cfg_lower        = 16'(LOWER_EDGE_RST);
      cfg_center       = 16'(CENTER_POINT_RST);
      cfg_upper        = 16'(UPPER_EDGE_RST);
      cfg_shape        = SHAPE_SELECT_RST;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = directed_rows[i];
         if (row.is_write) begin
            if (i > 0 && !directed_rows[i-1].is_write) begin
               wait_drained();
               settings_used++;
            end
            write_reg(row.index, row.value);
         end else
            send_sample(row.sample, row.given, row.degree);
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_drained();
         configure_phase(p);
         pacing = pacing_type'(p % 4);
         if (p == 0)
            pressure_armed = 1'b1;
         repeat (PHASE_ITEMS)
            send_sample(pick_sample(), 1'b0, '0);
      end

      wait_drained();
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      $display("Summary: %0d samples over %0d curve settings (S and Z, step and wide spans),",
               samples_sent, settings_used);
      $display("         %0d degrees checked under four pacing patterns and a long hold-off",
               degrees_checked);
      if (fail_count == 0)
         $display("fuzzy_s_z_membership verification clean");
      else
         $display("fuzzy_s_z_membership verification failed");
      $finish;
   end

   // Watchdog
   initial begin
      #400000;
      $display("ERROR: timeout, %0d degrees still outstanding", pending_degrees.size());
      $display("fuzzy_s_z_membership verification failed");
      $finish;
   end

endmodule

// File: filelist.f
hdl/fszm_pkg.sv
hdl/fszm_if.sv
hdl/fszm_div_step.sv
hdl/fuzzy_s_z_membership.sv
bench/tb_top.sv
